// File: rtl/deuc_pkg.sv
package deuc_pkg;

	localparam int MEM_DEPTH_DEF = 1024;

	// composed bus address and its range compare width
	localparam int ADDR_W = 16;
	localparam int CMP_W  = 17;

	localparam logic [10:0] MEM_SIZE_RST    = 11'd256;
	localparam logic [15:0] WRITE_TICKS_RST = 16'd1000;

	// op codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// register selects
	localparam logic [2:0] SEL_CTRL   = 3'd0;
	localparam logic [2:0] SEL_UNLOCK = 3'd1;
	localparam logic [2:0] SEL_DATA   = 3'd2;
	localparam logic [2:0] SEL_ADRL   = 3'd3;
	localparam logic [2:0] SEL_ADRH   = 3'd4;

	// config register indexes
	localparam logic CFG_MEM_SIZE    = 1'b0;
	localparam logic CFG_WRITE_TICKS = 1'b1;

	// control register bits
	localparam int B_RD    = 0;
	localparam int B_WR    = 1;
	localparam int B_WREN  = 2;
	localparam int B_CFGS  = 6;
	localparam int B_EEPGD = 7;
	localparam logic [7:0] CTRL_MASK = 8'hCF;

	localparam logic [7:0] KEY_1 = 8'h55;
	localparam logic [7:0] KEY_2 = 8'hAA;

	typedef enum logic [4:0] {
		U_UNARMED  = 5'b00001,
		U_NOTREADY = 5'b00010,
		U_HAVE55   = 5'b00100,
		U_READY    = 5'b01000,
		U_WRITING  = 5'b10000
	} unlock_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOAD  = 3'b100
	} state_t;

endpackage

// File: rtl/deuc_ram.sv
module deuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/data_eeprom_unlock_controller.sv
// Data EEPROM register block with 0x55/0xAA write unlock and tick-timed writes.
// A result sits in the output register from the cycle after its beat is accepted.
// Throughput: one beat per cycle while m_tready frees the output register; a
// control write loading the data register from the store adds a registered read.
// Reset (arst_n low, asynchronous) clears the register file and presets config;
// the block then zeroes the whole store, s_tready low. Config writes go in anytime.
module data_eeprom_unlock_controller #(
	parameter int MEM_DEPTH = deuc_pkg::MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] wdata
	input  logic [4:0]  s_tuser,   // [1:0] op, [4:2] reg_sel
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] rdata, [8] eeif, [9] addr_error, rest zero
);

	import deuc_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	// config registers
	logic [10:0] mem_size_q;
	logic [15:0] write_ticks_q;

	// register file and write engine state
	state_t            state_q;
	unlock_t           unl_q, unl_d;
	logic [7:0]        ctrl_q, ctrl_d;
	logic [7:0]        data_q, data_d;
	logic [7:0]        alo_q, alo_d;
	logic [7:0]        ahi_q, ahi_d;
	logic [ADDR_W-1:0] paddr_q, paddr_d;
	logic [7:0]        pdata_q, pdata_d;
	logic [15:0]       cnt_q, cnt_d;
	logic [AW-1:0]     clr_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_rdata_q;
	logic       out_eeif_q;
	logic       out_err_q;

	// per-beat decode
	logic [1:0]        in_op;
	logic [2:0]        in_sel;
	logic [7:0]        in_wdata;
	logic              accept;
	logic [ADDR_W-1:0] cur_addr;
	logic              cur_ok;
	logic              pend_ok;
	logic [7:0]        v;
	logic              start;
	logic [7:0]        res_rdata;
	logic              res_eeif;
	logic              res_err;
	logic              upd_we;
	logic              upd_rd;

	// store port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	assign in_op    = s_tuser[1:0];
	assign in_sel   = s_tuser[4:2];
	assign in_wdata = s_tdata;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// high address byte only counts once more than 256 bytes are in use
	assign cur_addr = (mem_size_q > 11'd256) ? {ahi_q, alo_q} : {8'd0, alo_q};

	// in range of both mem_size and the physical depth
	assign cur_ok  = ({1'b0, cur_addr} < CMP_W'(mem_size_q)) &&
	                 ({1'b0, cur_addr} < CMP_W'(MEM_DEPTH));
	assign pend_ok = ({1'b0, paddr_q} < CMP_W'(mem_size_q)) &&
	                 ({1'b0, paddr_q} < CMP_W'(MEM_DEPTH));

	always_comb begin
		ctrl_d    = ctrl_q;
		unl_d     = unl_q;
		data_d    = data_q;
		alo_d     = alo_q;
		ahi_d     = ahi_q;
		paddr_d   = paddr_q;
		pdata_d   = pdata_q;
		cnt_d     = cnt_q;
		res_rdata = 8'd0;
		res_eeif  = 1'b0;
		res_err   = 1'b0;
		upd_we    = 1'b0;
		upd_rd    = 1'b0;
		start     = 1'b0;
		v         = in_wdata & CTRL_MASK;

		case (in_op)
			OP_WRITE: begin
				unique case (in_sel)
					SEL_CTRL: begin
						if (v[B_WREN]) begin
							if (unl_q == U_UNARMED) begin
								unl_d = U_NOTREADY;
							end else if (v[B_WR] && !v[B_RD] && unl_q == U_READY) begin
								// unlocked: latch address and data, arm the timer
								start   = 1'b1;
								unl_d   = U_WRITING;
								paddr_d = cur_addr;
								pdata_d = data_q;
								cnt_d   = (write_ticks_q == 16'd0) ? 16'd1 : write_ticks_q;
							end
						end else if (unl_q != U_WRITING) begin
							unl_d = U_UNARMED;
						end
						// WR only set by a real start; RD is sticky until served
						ctrl_d = v;
						ctrl_d[B_WR] = ctrl_q[B_WR] | start;
						ctrl_d[B_RD] = ctrl_q[B_RD] | v[B_RD];
						if (ctrl_d[B_RD] && !ctrl_d[B_WR]) begin
							unl_d = U_UNARMED;
							if (ctrl_d[B_EEPGD] || ctrl_d[B_CFGS]) begin
								res_err = 1'b1;
							end else if (cur_ok) begin
								upd_rd = 1'b1;
							end else begin
								res_err = 1'b1;
							end
							ctrl_d[B_RD] = 1'b0;
						end
					end
					SEL_UNLOCK: begin
						if (unl_q == U_NOTREADY && in_wdata == KEY_1) begin
							unl_d = U_HAVE55;
						end else if (unl_q == U_HAVE55 && in_wdata == KEY_2) begin
							unl_d = U_READY;
						end else if (unl_q == U_HAVE55 || unl_q == U_READY) begin
							unl_d = U_NOTREADY;
						end
					end
					SEL_DATA: data_d = in_wdata;
					SEL_ADRL: alo_d  = in_wdata;
					SEL_ADRH: ahi_d  = in_wdata;
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (in_sel)
					SEL_CTRL: res_rdata = ctrl_q;
					SEL_DATA: res_rdata = data_q;
					SEL_ADRL: res_rdata = alo_q;
					SEL_ADRH: res_rdata = ahi_q;
					default:  res_rdata = 8'd0;
				endcase
			end
			OP_TICK: begin
				if (cnt_q != 16'd0) begin
					cnt_d = cnt_q - 16'd1;
					if (cnt_q == 16'd1) begin
						// write completes on this tick
						if (ctrl_q[B_EEPGD] || ctrl_q[B_CFGS] || !pend_ok) begin
							res_err = 1'b1;
						end else begin
							upd_we = 1'b1;
						end
						ctrl_d[B_WR] = 1'b0;
						res_eeif     = 1'b1;
						unl_d        = ctrl_q[B_WREN] ? U_NOTREADY : U_UNARMED;
					end
				end
			end
			default: ;
		endcase
	end

	// store write port: clearing sweep after reset, else completing writes
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'd0;
		end else begin
			ram_we    = accept && upd_we;
			ram_waddr = paddr_q[AW-1:0];
			ram_wdata = pdata_q;
		end
	end

	deuc_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cur_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q    <= MEM_SIZE_RST;
			write_ticks_q <= WRITE_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MEM_SIZE) begin
				mem_size_q <= cfg_data[10:0];
			end else if (cfg_index == CFG_WRITE_TICKS) begin
				write_ticks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			unl_q   <= U_UNARMED;
			ctrl_q  <= 8'd0;
			data_q  <= 8'd0;
			alo_q   <= 8'd0;
			ahi_q   <= 8'd0;
			paddr_q <= '0;
			pdata_q <= 8'd0;
			cnt_q   <= 16'd0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unl_q   <= unl_d;
						ctrl_q  <= ctrl_d;
						data_q  <= data_d;
						alo_q   <= alo_d;
						ahi_q   <= ahi_d;
						paddr_q <= paddr_d;
						pdata_q <= pdata_d;
						cnt_q   <= cnt_d;
						if (upd_rd) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					// registered store read returns the byte addressed by the accepted control write
					data_q  <= ram_rdata;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_rdata_q <= res_rdata;
			out_eeif_q  <= res_eeif;
			out_err_q   <= res_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_err_q, out_eeif_q, out_rdata_q};

	// WR is set exactly while the write timer runs
	a_wr_timer: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q[B_WR] == (cnt_q != 16'd0))
		else $error("WR bit and write timer disagree");

	// a write in flight always holds the writing unlock state
	a_wr_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q[B_WR] == (unl_q == U_WRITING))
		else $error("WR bit and unlock state disagree");

	// no beat taken while the store is being cleared or loaded
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_LOAD) |-> !s_tready)
		else $error("input accepted during clear or load");

	// a store load only follows an accepted control write
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(accept && in_op == OP_WRITE && in_sel == SEL_CTRL))
		else $error("store load without control write");

	// completion pulse never carries read data
	a_eeif_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_eeif_q) |-> (out_rdata_q == 8'd0))
		else $error("eeif with nonzero rdata");

endmodule

// File: tb/sv/data_eeprom_unlock_controller_tb.sv
module data_eeprom_unlock_controller_tb;

	import deuc_pkg::*;

	// codes the package leaves unnamed: the unused op and an unused register select
	localparam logic [1:0] OP_NONE  = 2'd3;
	localparam logic [2:0] SEL_NONE = 3'd7;

	// control register bit masks
	localparam logic [7:0] M_RD    = 8'(1 << B_RD);
	localparam logic [7:0] M_WR    = 8'(1 << B_WR);
	localparam logic [7:0] M_WREN  = 8'(1 << B_WREN);
	localparam logic [7:0] M_CFGS  = 8'(1 << B_CFGS);
	localparam logic [7:0] M_EEPGD = 8'(1 << B_EEPGD);

	// run guard: ~1000 beats plus the store clear
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] sel;
		logic [7:0] wdata;
	} bus_op_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       eeif;
		logic       addr_error;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] wdata
	logic [4:0]  s_tuser = '0;    // [1:0] op, [4:2] reg_sel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [7:0] rdata, [8] eeif, [9] addr_error

	data_eeprom_unlock_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the register block. Updated once per accepted input beat.
	// ------------------------------------------------------------------
	logic [10:0] mem_size_q = MEM_SIZE_RST;
	logic [15:0] ticks_q    = WRITE_TICKS_RST;
	logic [7:0]  ctl_q      = '0;
	unlock_t     lock_q     = U_UNARMED;
	logic [7:0]  data_q     = '0;
	logic [7:0]  adrl_q     = '0;
	logic [7:0]  adrh_q     = '0;
	logic [15:0] pend_addr  = '0;
	logic [7:0]  pend_data  = '0;
	logic [15:0] countdown  = '0;
	logic [7:0]  ee_mem [MEM_DEPTH_DEF];

	// size above the array depth clamps; zero means nothing is in range
	function automatic int eff_size();
		return (mem_size_q > MEM_DEPTH_DEF) ? MEM_DEPTH_DEF : int'(mem_size_q);
	endfunction

	// high address byte only counts for parts larger than 256 bytes
	function automatic logic [15:0] cur_addr();
		return (mem_size_q > 11'd256) ? {adrh_q, adrl_q} : {8'h00, adrl_q};
	endfunction

	// control register write; returns the address error flag
	function automatic logic ctl_write(input logic [7:0] raw);
		logic [7:0]  v;
		logic        err;
		logic [15:0] a;
		err = 1'b0;
		v = raw & CTRL_MASK;
		if (v[B_WREN]) begin
			if (lock_q == U_UNARMED)
				lock_q = U_NOTREADY;
			else if (v[B_WR] && !v[B_RD] && lock_q == U_READY) begin
				// write really starts: latch address and data, arm the timer
				ctl_q[B_WR] = 1'b1;
				pend_addr = cur_addr();
				pend_data = data_q;
				countdown = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
				lock_q = U_WRITING;
			end
		end else if (lock_q != U_WRITING) begin
			lock_q = U_UNARMED;
		end
		// RD sticks until served, WR only ever set by a real start
		ctl_q = (ctl_q & (M_RD | M_WR)) | (v & ~M_WR);
		if (ctl_q[B_RD] && !ctl_q[B_WR]) begin
			lock_q = U_UNARMED;
			if (ctl_q[B_EEPGD] || ctl_q[B_CFGS]) begin
				err = 1'b1;
			end else begin
				a = cur_addr();
				if (a < eff_size())
					data_q = ee_mem[a];
				else
					err = 1'b1;
			end
			ctl_q[B_RD] = 1'b0;
		end
		return err;
	endfunction

	function automatic void key_write(input logic [7:0] v);
		if (lock_q == U_NOTREADY && v == KEY_1)
			lock_q = U_HAVE55;
		else if (lock_q == U_HAVE55 && v == KEY_2)
			lock_q = U_READY;
		else if (lock_q == U_HAVE55 || lock_q == U_READY)
			lock_q = U_NOTREADY;
	endfunction

	// result of one register access or tick
	function automatic access_result_t ee_access(input bus_op_t b);
		access_result_t r;
		r = '0;
		case (b.op)
			OP_WRITE: begin
				case (b.sel)
					SEL_CTRL:   r.addr_error = ctl_write(b.wdata);
					SEL_UNLOCK: key_write(b.wdata);
					SEL_DATA:   data_q = b.wdata;
					SEL_ADRL:   adrl_q = b.wdata;
					SEL_ADRH:   adrh_q = b.wdata;
					default:    ;
				endcase
			end
			OP_READ: begin
				case (b.sel)
					SEL_CTRL: r.rdata = ctl_q;
					SEL_DATA: r.rdata = data_q;
					SEL_ADRL: r.rdata = adrl_q;
					SEL_ADRH: r.rdata = adrh_q;
					default:  r.rdata = 8'h00;
				endcase
			end
			OP_TICK: begin
				if (countdown != 16'd0) begin
					countdown = countdown - 16'd1;
					if (countdown == 16'd0) begin
						// completion: bad target still pulses eeif but leaves the store alone
						if (ctl_q[B_EEPGD] || ctl_q[B_CFGS] || pend_addr >= eff_size())
							r.addr_error = 1'b1;
						else
							ee_mem[pend_addr] = pend_data;
						ctl_q[B_WR] = 1'b0;
						r.eeif = 1'b1;
						lock_q = ctl_q[B_WREN] ? U_NOTREADY : U_UNARMED;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Bookkeeping
	// ------------------------------------------------------------------
	bus_op_t        bus_ops_q[$];     // beats waiting to be driven
	access_result_t due_result_q[$];  // predicted results, oldest first
	bus_op_t        on_bus;
	access_result_t rx_want;
	int             rx_gap;
	int             tx_wait = 0;
	int             rx_wait = 0;
	bit             calm_tx = 1'b0;
	bit             calm_rx = 1'b0;
	int             n_pushed = 0;
	int             n_checked = 0;
	int             n_err = 0;
	int             cyc = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch @%0d: %s got 0x%0h want 0x%0h", cyc, what, got, want);
		n_err++;
	endtask

	// per-beat idle draw; flips into and out of stretches with no idling at all
	function automatic int idle_cycles(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		if (calm)
			return 0;
		if ($urandom_range(0, 1) == 1)
			return $urandom_range(0, 2);
		return $urandom_range(0, 17);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued beats, predicts each one as it is accepted
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_tvalid && s_tready)
				due_result_q.push_back(ee_access(on_bus));
			if (!s_tvalid || s_tready) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
					s_tvalid <= 1'b0;
				end else if (bus_ops_q.size() != 0) begin
					on_bus = bus_ops_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= on_bus.wdata;
					s_tuser <= {on_bus.sel, on_bus.op};
					tx_wait <= idle_cycles(calm_tx);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random backpressure, field-by-field compare on every beat
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			if (due_result_q.size() == 0) begin
				report_mismatch("result beat with nothing due", m_tdata, 0);
			end else begin
				rx_want = due_result_q.pop_front();
				if (m_tdata[7:0] !== rx_want.rdata)
					report_mismatch("rdata", m_tdata[7:0], rx_want.rdata);
				if (m_tdata[8] !== rx_want.eeif)
					report_mismatch("eeif", m_tdata[8], rx_want.eeif);
				if (m_tdata[9] !== rx_want.addr_error)
					report_mismatch("addr_error", m_tdata[9], rx_want.addr_error);
			end
			n_checked <= n_checked + 1;
			rx_gap = idle_cycles(calm_rx);
			rx_wait <= rx_gap;
			m_tready <= (rx_gap == 0);
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
		end else begin
			rx_wait <= 0;
			m_tready <= 1'b1;
		end
	end

	// run guard, covers the store clear after reset too
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("data_eeprom_unlock_controller_tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic push_beat(input logic [1:0] op, input logic [2:0] sel,
			input logic [7:0] wdata);
		bus_op_t b;
		b.op = op;
		b.sel = sel;
		b.wdata = wdata;
		bus_ops_q.push_back(b);
		n_pushed++;
	endtask

	// mostly in range, sometimes right at the edge, sometimes anywhere
	task automatic load_addr();
		int          lim;
		logic [15:0] a;
		lim = eff_size();
		if (lim == 0 || $urandom_range(0, 7) == 0)
			a = 16'($urandom_range(0, 16'hFFFF));
		else if ($urandom_range(0, 9) == 0)
			a = 16'(lim);
		else
			a = 16'($urandom_range(0, lim - 1));
		push_beat(OP_WRITE, SEL_ADRL, a[7:0]);
		push_beat(OP_WRITE, SEL_ADRH, a[15:8]);
	endtask

	// unlock-and-write with random content; broken ones spoil one step
	task automatic write_seq(input bit broken);
		logic [7:0] v;
		int         fault;
		int         n_ticks;
		load_addr();
		push_beat(OP_WRITE, SEL_DATA, 8'($urandom_range(0, 255)));
		push_beat(OP_WRITE, SEL_CTRL, M_WREN | (($urandom_range(0, 3) == 0) ? 8'h08 : 8'h00));
		fault = broken ? $urandom_range(0, 3) : 4;
		if (fault == 0)
			push_beat(OP_WRITE, SEL_UNLOCK, 8'($urandom_range(0, 255)));
		else
			push_beat(OP_WRITE, SEL_UNLOCK, KEY_1);
		if (fault == 1)
			push_beat(OP_WRITE, SEL_CTRL, 8'h00);   // drops WREN, disarms
		push_beat(OP_WRITE, SEL_UNLOCK, (fault == 2) ? KEY_1 : KEY_2);
		v = M_WREN | M_WR;
		if ($urandom_range(0, 7) == 0)
			v |= M_RD;                               // RD with WR: no write starts, the read is served
		if ($urandom_range(0, 9) == 0)
			v |= ($urandom_range(0, 1) == 1) ? M_EEPGD : M_CFGS;
		if ($urandom_range(0, 5) == 0)
			v |= 8'($urandom_range(0, 255)) & 8'h38;
		if (fault == 3)
			v &= ~M_WREN;                            // WR without WREN
		push_beat(OP_WRITE, SEL_CTRL, v);
		n_ticks = ((ticks_q == 16'd0) ? 1 : ((ticks_q > 16'd8) ? 8 : int'(ticks_q)))
			+ $urandom_range(0, 2) - (($urandom_range(0, 5) == 0) ? 1 : 0);
		for (int i = 0; i < n_ticks; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: push_beat(OP_READ, SEL_CTRL, 8'h00);
					1: push_beat(OP_WRITE, SEL_CTRL, M_WREN | M_RD);  // read while busy
					2: push_beat(OP_WRITE, SEL_CTRL, 8'h00);          // WREN off mid-write
					default: push_beat(OP_READ, SEL_DATA, 8'h00);
				endcase
			end
			push_beat(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
		end
		// read the byte back
		push_beat(OP_WRITE, SEL_CTRL, M_RD | (($urandom_range(0, 1) == 1) ? M_WREN : 8'h00));
		push_beat(OP_READ, SEL_DATA, 8'h00);
		push_beat(OP_READ, SEL_CTRL, 8'h00);
	endtask

	task automatic read_seq();
		logic [7:0] v;
		load_addr();
		v = M_RD | (($urandom_range(0, 1) == 1) ? M_WREN : 8'h00);
		if ($urandom_range(0, 7) == 0)
			v |= ($urandom_range(0, 1) == 1) ? M_EEPGD : M_CFGS;
		push_beat(OP_WRITE, SEL_CTRL, v);
		push_beat(OP_READ, SEL_DATA, 8'h00);
		push_beat(OP_READ, 3'($urandom_range(0, 7)), 8'h00);
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 4))
			push_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
				8'($urandom_range(0, 255)));
	endtask

	task automatic random_traffic(input int n_beats);
		int stop_at;
		stop_at = n_pushed + n_beats;
		while (n_pushed < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: write_seq(1'b0);
				5, 6:          read_seq();
				7:             write_seq(1'b1);
				default:       noise_burst();
			endcase
		end
	endtask

	// sender holds off until every due result is back
	task automatic wait_drained();
		do @(posedge clk); while (n_checked < n_pushed);
		repeat (4) @(posedge clk);
	endtask

	// both registers, back to back, on an idle block
	task automatic set_config(input logic [15:0] msz, input logic [15:0] ticks);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MEM_SIZE;
		cfg_data <= msz;
		@(posedge clk);
		mem_size_q = msz[10:0];
		cfg_index <= CFG_WRITE_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		ticks_q = ticks;
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		foreach (ee_mem[i])
			ee_mem[i] = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of every select, unused selects and the unused op
		for (int s = 0; s < 8; s++)
			push_beat(OP_READ, 3'(s), 8'h00);
		push_beat(OP_NONE, SEL_NONE, 8'hFF);
		push_beat(OP_WRITE, SEL_NONE, 8'hFF);
		push_beat(OP_READ, SEL_NONE, 8'h00);

		// full-size part, zero write time behaves as one tick
		set_config(16'd1024, 16'd0);
		push_beat(OP_WRITE, SEL_ADRL, 8'hFF);
		push_beat(OP_WRITE, SEL_ADRH, 8'h03);
		push_beat(OP_WRITE, SEL_DATA, 8'hA5);
		push_beat(OP_WRITE, SEL_CTRL, M_WREN);
		push_beat(OP_WRITE, SEL_UNLOCK, KEY_1);
		push_beat(OP_WRITE, SEL_UNLOCK, KEY_2);
		push_beat(OP_WRITE, SEL_CTRL, M_WREN | M_WR);
		push_beat(OP_READ, SEL_CTRL, 8'h00);
		push_beat(OP_TICK, SEL_CTRL, 8'h00);            // completes, eeif
		push_beat(OP_TICK, SEL_CTRL, 8'h00);            // nothing pending
		push_beat(OP_WRITE, SEL_CTRL, M_WREN | M_RD);   // read back top byte
		push_beat(OP_READ, SEL_DATA, 8'h00);
		push_beat(OP_WRITE, SEL_ADRH, 8'h04);
		push_beat(OP_WRITE, SEL_CTRL, M_RD);            // out of range
		push_beat(OP_WRITE, SEL_CTRL, M_EEPGD | M_RD);  // program memory read
		push_beat(OP_WRITE, SEL_CTRL, 8'h00);
		push_beat(OP_READ, SEL_CTRL, 8'h00);

		// random phases over a spread of sizes and write times
		random_traffic(120);
		set_config(16'd1, 16'd1);
		random_traffic(100);
		set_config(16'd256, 16'd5);
		random_traffic(150);
		set_config(16'd0, 16'd2);       // nothing in range
		random_traffic(80);
		set_config(16'd2047, 16'd4);    // clamps to the array depth
		random_traffic(150);
		set_config(16'd300, 16'd1);
		random_traffic(150);
		set_config(16'd17, 16'd6);
		random_traffic(100);
		// longest write time last: a write started here never has to finish
		set_config(16'd1024, 16'hFFFF);
		random_traffic(30);

		wait_drained();
		repeat (8) @(posedge clk);
		if (due_result_q.size() != 0)
			report_mismatch("results never arrived", due_result_q.size(), 0);
		if (n_err == 0)
			$display("data_eeprom_unlock_controller_tb: done, clean");
		else
			$display("data_eeprom_unlock_controller_tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/deuc_pkg.sv
rtl/deuc_ram.sv
rtl/data_eeprom_unlock_controller.sv
tb/sv/data_eeprom_unlock_controller_tb.sv
